### sv/flux_encoding_detector_top_macros.svh
// Assertion shorthands for the flux encoding detector checker.
`ifndef FLUX_ENCODING_DETECTOR_TOP_MACROS_SVH
`define FLUX_ENCODING_DETECTOR_TOP_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define FDET_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define FDET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/fdet_pkg.sv
package fdet_pkg;

  localparam int unsigned BINS_DEF      = 256;
  localparam int unsigned MAX_PEAKS_DEF = 16;
  localparam int unsigned CFG_W         = 27;

  localparam logic [8:0]  MARK_MAX  = 9'd511;
  localparam logic [29:0] RATE_MAX  = 30'd1000000000;
  localparam logic [15:0] CENT_MAX  = 16'hffff;
  localparam logic [4:0]  COUNT_MAX = 5'd31;

  localparam logic [7:0]  REV_RST  = 8'd1;
  localparam logic [26:0] CLK_RST  = 27'd24000000;
  localparam logic [15:0] THR_RST  = 16'd16;
  localparam logic [15:0] CMIN_RST = 16'd64;

  typedef enum logic [1:0] {
    CFG_REVOLUTION    = 2'd0,
    CFG_SAMPLE_CLOCK  = 2'd1,
    CFG_BIN_THRESHOLD = 2'd2,
    CFG_CLUSTER_MIN   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ENC_UNKNOWN = 2'd0,
    ENC_FM      = 2'd1,
    ENC_MFM     = 2'd2
  } enc_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] pulse_len;
    logic        index_mark;
  } item_t;

  typedef struct packed {
    logic [1:0]  encoding;
    logic [29:0] rate_hz;
    logic [4:0]  peak_count;
    logic [15:0] first_peak;
  } result_t;

  // Control of the histogram stream into the peak finder
  typedef struct packed {
    logic clear;
    logic valid;
  } beat_ctl_t;

endpackage

### sv/fdet_peak.sv
module fdet_peak #(
  parameter int unsigned BINS      = fdet_pkg::BINS_DEF,
  parameter int unsigned MAX_PEAKS = fdet_pkg::MAX_PEAKS_DEF,
  localparam int unsigned IDXW = $clog2(BINS),
  localparam int unsigned CW   = IDXW + 1,
  localparam int unsigned MW   = 32 + IDXW,
  localparam int unsigned WW   = 32 + 2 * IDXW,
  localparam int unsigned NW   = $clog2(MAX_PEAKS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fdet_pkg::beat_ctl_t ctl_i,
  input  logic [31:0]         data_i,
  input  logic [15:0]         thr_i,
  input  logic [15:0]         cmin_i,
  output logic                done_o,
  output logic [NW-1:0]       count_o,
  output logic [WW-1:0]       wsum0_o,
  output logic [MW-1:0]       mass0_o,
  output logic [WW-1:0]       wsum1_o,
  output logic [MW-1:0]       mass1_o
);

  logic [CW-1:0]   idx_q;
  logic [31:0]     l_q, m_q;
  logic [33:0]     sum3;
  logic            v1_q, last1_q;
  logic [IDXW-1:0] j1_q;
  logic [31:0]     s1_q;
  logic            v2_q, last2_q, hit2_q;
  logic [MW-1:0]   prod2_q;
  logic [31:0]     s2_q;
  logic            inrun_q, done_q;
  logic [NW-1:0]   cnt_q;
  logic [WW-1:0]   wsum_q, tw;
  logic [MW-1:0]   mass_q, tm;
  logic            close_run, kept;
  logic [WW-1:0]   wsum0_q, wsum1_q;
  logic [MW-1:0]   mass0_q, mass1_q;

  // Three-tap window sum
  assign sum3 = {2'b00, l_q} + {1'b0, m_q, 1'b0} + {2'b00, data_i};

  // Run totals including the current bin
  assign tw = wsum_q + (hit2_q ? WW'(prod2_q) : '0);
  assign tm = mass_q + (hit2_q ? MW'(s2_q) : '0);
  assign close_run = v2_q && ((hit2_q && last2_q) || (!hit2_q && inrun_q));
  assign kept = tm > MW'(cmin_i);

  // Control: beat index, stage valids, run state, peak count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      v1_q    <= 1'b0;
      last1_q <= 1'b0;
      v2_q    <= 1'b0;
      last2_q <= 1'b0;
      inrun_q <= 1'b0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else if (ctl_i.clear) begin
      idx_q   <= '0;
      v1_q    <= 1'b0;
      last1_q <= 1'b0;
      v2_q    <= 1'b0;
      last2_q <= 1'b0;
      inrun_q <= 1'b0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      v1_q    <= ctl_i.valid && (idx_q != '0);
      last1_q <= ctl_i.valid && (idx_q == CW'(BINS));
      if (ctl_i.valid) begin
        idx_q <= idx_q + CW'(1);
      end
      v2_q    <= v1_q;
      last2_q <= last1_q;
      done_q  <= v2_q && last2_q;
      if (close_run) begin
        inrun_q <= 1'b0;
        if (kept && (cnt_q < NW'(MAX_PEAKS))) begin
          cnt_q <= cnt_q + NW'(1);
        end
      end else if (v2_q && hit2_q) begin
        inrun_q <= 1'b1;
      end
    end
  end

  // Datapath: smooth, weight, accumulate
  always_ff @(posedge clk_i) begin
    if (ctl_i.clear) begin
      l_q    <= '0;
      m_q    <= '0;
      wsum_q <= '0;
      mass_q <= '0;
    end else begin
      if (ctl_i.valid) begin
        l_q  <= m_q;
        m_q  <= data_i;
        s1_q <= sum3[33:2];
        j1_q <= IDXW'(idx_q - CW'(1));
      end
      prod2_q <= MW'(j1_q) * MW'(s1_q);
      s2_q    <= s1_q;
      hit2_q  <= s1_q >= 32'(thr_i);
      if (close_run) begin
        wsum_q <= '0;
        mass_q <= '0;
        if (kept && (cnt_q == NW'(0))) begin
          wsum0_q <= tw;
          mass0_q <= tm;
        end
        if (kept && (cnt_q == NW'(1))) begin
          wsum1_q <= tw;
          mass1_q <= tm;
        end
      end else if (v2_q && hit2_q) begin
        wsum_q <= tw;
        mass_q <= tm;
      end
    end
  end

  assign done_o  = done_q;
  assign count_o = cnt_q;
  assign wsum0_o = wsum0_q;
  assign mass0_o = mass0_q;
  assign wsum1_o = wsum1_q;
  assign mass1_o = mass1_q;

endmodule

### sv/fdet_div.sv
module fdet_div #(
  parameter int unsigned NUMW = 48,
  parameter int unsigned DENW = 40
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NUMW-1:0] num_i,
  input  logic [DENW-1:0] den_i,
  output logic            done_o,
  output logic [NUMW-1:0] quo_o
);

  localparam int unsigned SW = $clog2(NUMW + 1);

  logic [SW-1:0]   step_q;
  logic            done_q;
  logic [NUMW-1:0] q_q;
  logic [DENW-1:0] rem_q, den_q;
  logic [DENW:0]   rem_sh;
  logic            ge;

  // One quotient bit per cycle, restoring
  assign rem_sh = {rem_q, q_q[NUMW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= step_q == SW'(1);
      if (start_i) begin
        step_q <= SW'(NUMW);
      end else if (step_q != '0) begin
        step_q <= step_q - SW'(1);
      end
    end
  end

  // Shift numerator out, quotient in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      q_q   <= num_i;
      den_q <= den_i;
    end else if (step_q != '0) begin
      rem_q <= ge ? DENW'(rem_sh - {1'b0, den_q}) : DENW'(rem_sh);
      q_q   <= {q_q[NUMW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = q_q;

endmodule

### sv/flux_encoding_detector_top.sv
// Flux encoding detector.
// Input: start_i with in_i is taken when busy_o is low. A flux pulse item
// (kind 0) counts index marks and, during the selected revolution, bumps one
// histogram bin in the on-chip memory: read on the accept cycle, written back
// on the next. An end item (kind 1) walks all BINS bins once (one memory
// read per cycle, zeroing each bin behind the read), drains a 3-stage peak
// pipeline, then runs up to three restoring divisions on one shared divider
// (first and second centroid, bit rate), one quotient bit per cycle over a
// 40 + 2*log2(BINS)-bit numerator.
// Output: done_o strobes for one cycle with res_o; the receiver cannot stall,
// so it must take the transfer in that cycle. One result per end item.
// Configuration: cfg_we_i writes register cfg_idx_i at once; write only while
// busy_o is low.
// Reset: a clearing pass zeroes the BINS-entry memory, one bin a cycle, with
// busy_o high throughout; registers return to their defaults.
module flux_encoding_detector_top #(
  parameter int unsigned BINS      = fdet_pkg::BINS_DEF,
  parameter int unsigned MAX_PEAKS = fdet_pkg::MAX_PEAKS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  fdet_pkg::item_t          in_i,
  output logic                     busy_o,
  output logic                     done_o,
  output fdet_pkg::result_t        res_o,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [fdet_pkg::CFG_W-1:0] cfg_data_i
);

  localparam int unsigned IDXW = $clog2(BINS);
  localparam int unsigned CW   = IDXW + 1;
  localparam int unsigned MW   = 32 + IDXW;
  localparam int unsigned WW   = 32 + 2 * IDXW;
  localparam int unsigned NW   = $clog2(MAX_PEAKS + 1);
  localparam int unsigned NUMW = (WW + 8 > 37) ? WW + 8 : 37;
  localparam int unsigned DENW = (MW > 16) ? MW : 16;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_BUMP, S_WALK, S_PEAK, S_DIV0, S_DIV1, S_EVAL, S_RATE, S_REPORT
  } state_e;

  state_e state_q;

  logic [7:0]  rev_q;
  logic [26:0] clk_q;
  logic [15:0] thr_q, cmin_q;

  logic [8:0]      mark_q, mark_d;
  logic [CW-1:0]   addr_q;
  logic            bump_q;
  logic [IDXW-1:0] bin_q;
  logic [15:0]     p0_q, second_peak_q;
  logic [1:0]      enc_q;
  logic [29:0]     rate_q;
  logic            done_q;
  fdet_pkg::result_t res_q;
  logic            div_go_q;
  logic [NUMW-1:0] div_num_q;
  logic [DENW-1:0] div_den_q;

  logic [31:0]     hist_mem [BINS];
  logic [31:0]     rd_q;
  logic            mem_we, mem_re;
  logic [IDXW-1:0] mem_wa, mem_ra;
  logic [31:0]     mem_wd;
  logic [CW-1:0]   walk_prev;

  logic            accept, is_mark, in_range;
  logic [7:0]      rev_eff;
  logic            mfm;
  logic [15:0]     quo16;
  logic [NUMW-1:0] rate_num;

  fdet_pkg::beat_ctl_t beat;
  logic [31:0]     beat_data;
  logic            pk_done, div_done;
  logic [NW-1:0]   pk_cnt;
  logic [WW-1:0]   wsum0, wsum1;
  logic [MW-1:0]   mass0, mass1;
  logic [NUMW-1:0] div_quo;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rev_q  <= fdet_pkg::REV_RST;
      clk_q  <= fdet_pkg::CLK_RST;
      thr_q  <= fdet_pkg::THR_RST;
      cmin_q <= fdet_pkg::CMIN_RST;
    end else if (cfg_we_i) begin
      case (fdet_pkg::cfg_idx_e'(cfg_idx_i))
        fdet_pkg::CFG_REVOLUTION:    rev_q  <= cfg_data_i[7:0];
        fdet_pkg::CFG_SAMPLE_CLOCK:  clk_q  <= cfg_data_i[26:0];
        fdet_pkg::CFG_BIN_THRESHOLD: thr_q  <= cfg_data_i[15:0];
        fdet_pkg::CFG_CLUSTER_MIN:   cmin_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Item decode
  assign accept   = start_i && (state_q == S_IDLE);
  assign is_mark  = (in_i.pulse_len == '0) || in_i.index_mark;
  assign in_range = in_i.pulse_len < 32'(BINS);
  assign rev_eff  = (rev_q == '0) ? 8'd1 : rev_q;
  assign mark_d   = (is_mark && (mark_q != fdet_pkg::MARK_MAX)) ? mark_q + 9'd1 : mark_q;

  // Memory port control
  assign walk_prev = addr_q - CW'(1);
  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_q[IDXW-1:0];
    mem_wd = '0;
    mem_re = accept && !in_i.kind && in_range;
    mem_ra = in_i.pulse_len[IDXW-1:0];
    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_BUMP: begin
        mem_we = bump_q;
        mem_wa = bin_q;
        mem_wd = (rd_q == '1) ? rd_q : rd_q + 32'd1;
      end
      S_WALK: begin
        mem_we = (addr_q != '0) && (addr_q <= CW'(BINS));
        mem_wa = walk_prev[IDXW-1:0];
        mem_re = addr_q < CW'(BINS);
        mem_ra = addr_q[IDXW-1:0];
      end
      default: ;
    endcase
  end

  // Histogram memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= hist_mem[mem_ra];
    end
  end

  // Stream the walk into the peak finder, padded with one zero beat
  assign beat.clear = accept && in_i.kind;
  assign beat.valid = (state_q == S_WALK) && (addr_q != '0);
  assign beat_data  = (addr_q <= CW'(BINS)) ? rd_q : '0;

  fdet_peak #(
    .BINS      (BINS),
    .MAX_PEAKS (MAX_PEAKS)
  ) u_peak (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (beat),
    .data_i  (beat_data),
    .thr_i   (thr_q),
    .cmin_i  (cmin_q),
    .done_o  (pk_done),
    .count_o (pk_cnt),
    .wsum0_o (wsum0),
    .mass0_o (mass0),
    .wsum1_o (wsum1),
    .mass1_o (mass1)
  );

  fdet_div #(
    .NUMW (NUMW),
    .DENW (DENW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .num_i   (div_num_q),
    .den_i   (div_den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Saturated centroid, encoding decision, rate numerator
  assign quo16 = (div_quo > NUMW'(fdet_pkg::CENT_MAX)) ? fdet_pkg::CENT_MAX : div_quo[15:0];
  assign mfm   = (pk_cnt >= NW'(2)) &&
                 ((19'(second_peak_q) << 2) < (19'(p0_q) * 19'd7));
  assign rate_num = (NUMW'({clk_q, 8'd0}) << mfm) + NUMW'(p0_q[15:1]);

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      addr_q        <= '0;
      mark_q        <= '0;
      bump_q        <= 1'b0;
      bin_q         <= '0;
      p0_q          <= '0;
      second_peak_q <= '0;
      enc_q         <= fdet_pkg::ENC_UNKNOWN;
      rate_q        <= '0;
      done_q        <= 1'b0;
      res_q         <= '0;
      div_go_q      <= 1'b0;
      div_num_q     <= '0;
      div_den_q     <= '0;
    end else begin
      done_q   <= 1'b0;
      div_go_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          addr_q <= addr_q + CW'(1);
          if (addr_q == CW'(BINS - 1)) begin
            addr_q  <= '0;
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            addr_q <= '0;
            if (in_i.kind) begin
              state_q <= S_WALK;
            end else begin
              mark_q  <= mark_d;
              bump_q  <= (in_i.pulse_len != '0) && in_range && (mark_d == {1'b0, rev_eff});
              bin_q   <= in_i.pulse_len[IDXW-1:0];
              state_q <= S_BUMP;
            end
          end
        end
        S_BUMP: begin
          state_q <= S_IDLE;
        end
        S_WALK: begin
          addr_q <= addr_q + CW'(1);
          if (addr_q == CW'(BINS + 1)) begin
            state_q <= S_PEAK;
          end
        end
        S_PEAK: begin
          if (pk_done) begin
            if (pk_cnt == '0) begin
              p0_q          <= '0;
              second_peak_q <= '0;
              enc_q         <= fdet_pkg::ENC_UNKNOWN;
              rate_q        <= '0;
              state_q       <= S_REPORT;
            end else begin
              div_go_q  <= 1'b1;
              div_num_q <= NUMW'({wsum0, 8'd0});
              div_den_q <= DENW'(mass0);
              state_q   <= S_DIV0;
            end
          end
        end
        S_DIV0: begin
          if (div_done) begin
            p0_q <= quo16;
            if (pk_cnt >= NW'(2)) begin
              div_go_q  <= 1'b1;
              div_num_q <= NUMW'({wsum1, 8'd0});
              div_den_q <= DENW'(mass1);
              state_q   <= S_DIV1;
            end else begin
              second_peak_q <= '0;
              state_q       <= S_EVAL;
            end
          end
        end
        S_DIV1: begin
          if (div_done) begin
            second_peak_q <= quo16;
            state_q       <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (pk_cnt < NW'(2)) begin
            enc_q <= fdet_pkg::ENC_UNKNOWN;
          end else if (mfm) begin
            enc_q <= fdet_pkg::ENC_MFM;
          end else begin
            enc_q <= fdet_pkg::ENC_FM;
          end
          if (p0_q == '0) begin
            rate_q  <= fdet_pkg::RATE_MAX;
            state_q <= S_REPORT;
          end else begin
            div_go_q  <= 1'b1;
            div_num_q <= rate_num;
            div_den_q <= DENW'(p0_q);
            state_q   <= S_RATE;
          end
        end
        S_RATE: begin
          if (div_done) begin
            rate_q  <= (div_quo > NUMW'(fdet_pkg::RATE_MAX)) ? fdet_pkg::RATE_MAX
                                                              : div_quo[29:0];
            state_q <= S_REPORT;
          end
        end
        S_REPORT: begin
          done_q           <= 1'b1;
          res_q.encoding   <= enc_q;
          res_q.rate_hz    <= rate_q;
          res_q.peak_count <= (32'(pk_cnt) > 32'(fdet_pkg::COUNT_MAX)) ?
                              fdet_pkg::COUNT_MAX : 5'(pk_cnt);
          res_q.first_peak <= p0_q;
          mark_q           <= '0;
          state_q          <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### sv/fdet_checker.sv
`include "flux_encoding_detector_top_macros.svh"

module fdet_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input fdet_pkg::item_t            in_i,
  input logic                       busy_o,
  input logic                       done_o,
  input fdet_pkg::result_t          res_o,
  input logic                       cfg_we_i,
  input logic [1:0]                 cfg_idx_i,
  input logic [fdet_pkg::CFG_W-1:0] cfg_data_i
);

  // An accepted transfer keeps the block busy in the next cycle
  `FDET_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o, "accept did not raise busy")

  // A result strobe lasts one cycle
  `FDET_ASSERT_NEXT(a_done_single, done_o, !done_o, "result strobe held")

  // A result only follows work in progress
  `FDET_ASSERT_SAME(a_done_busy, done_o, $past(busy_o), "result without work")

  // No peaks gives an all-zero report
  `FDET_ASSERT_SAME(a_no_peak, done_o && (res_o.peak_count == 5'd0),
    (res_o.rate_hz == 30'd0) && (res_o.first_peak == 16'd0) &&
    (res_o.encoding == fdet_pkg::ENC_UNKNOWN), "nonzero report with no peak")

  // Fewer than two peaks cannot decide the encoding
  `FDET_ASSERT_SAME(a_one_peak, done_o && (res_o.peak_count < 5'd2),
    res_o.encoding == fdet_pkg::ENC_UNKNOWN, "encoding set with under two peaks")

endmodule

bind flux_encoding_detector_top fdet_checker u_fdet_checker (.*);

### test/tb_flux_encoding_detector_top.sv
`timescale 1ns / 1ps

module tb_flux_encoding_detector_top;

  localparam int unsigned NBINS    = fdet_pkg::BINS_DEF;
  localparam int unsigned NPEAKS   = fdet_pkg::MAX_PEAKS_DEF;
  localparam int unsigned SETTLE   = 800;
  localparam int unsigned MAX_GAP  = 18;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start_i = 1'b0;
  fdet_pkg::item_t            in_i = '0;
  logic                       busy_o;
  logic                       done_o;
  fdet_pkg::result_t          res_o;
  logic                       cfg_we_i = 1'b0;
  logic [1:0]                 cfg_idx_i = '0;
  logic [fdet_pkg::CFG_W-1:0] cfg_data_i = '0;

  // Shadow of the block's state and registers
  logic [31:0] hist_q [NBINS];
  logic [31:0] smooth_q [NBINS];
  logic [8:0]  marks_q;
  logic [7:0]  rev_q;
  logic [26:0] clk_hz_q;
  logic [15:0] thr_q;
  logic [15:0] cmin_q;

  fdet_pkg::result_t report_q[$];
  int unsigned mismatches = 0;
  int unsigned reports_seen = 0;
  int unsigned items_sent = 0;
  int unsigned enc_seen [3];
  bit          no_gaps = 1'b0;

  flux_encoding_detector_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .in_i       (in_i),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Count marks and bump the histogram bin for one flux pulse
  task automatic model_pulse(input logic [31:0] len, input logic mark);
    logic [8:0] rev;
    rev = (rev_q == 8'd0) ? 9'd1 : {1'b0, rev_q};
    if ((len == 32'd0 || mark) && marks_q != fdet_pkg::MARK_MAX) marks_q++;
    if (len != 32'd0 && marks_q == rev && len < NBINS) begin
      if (hist_q[len] != 32'hffff_ffff) hist_q[len]++;
    end
  endtask

  // Smooth, find peaks, classify, work out the rate; clear the histogram and marks afterwards
  function automatic fdet_pkg::result_t analyze_track();
    fdet_pkg::result_t r;
    logic [15:0] peaks [NPEAKS];
    int unsigned cnt;
    int unsigned i;
    longint unsigned lft, rgt, wsum, mass, q, rem, c, num, mult;
    cnt = 0;
    for (i = 0; i < NBINS; i++) begin
      lft = (i > 0) ? hist_q[i-1] : 0;
      rgt = (i + 1 < NBINS) ? hist_q[i+1] : 0;
      smooth_q[i] = 32'((lft + 2 * longint'(hist_q[i]) + rgt) / 4);
    end
    i = 0;
    while (i < NBINS) begin
      if (smooth_q[i] < thr_q) begin
        i++;
      end else begin
        wsum = 0;
        mass = 0;
        while (i < NBINS && smooth_q[i] >= thr_q) begin
          wsum += longint'(i) * smooth_q[i];
          mass += smooth_q[i];
          i++;
        end
        if (mass > cmin_q && cnt < NPEAKS) begin
          q   = wsum / mass;
          rem = wsum % mass;
          c   = (q > 255) ? 65535 : q * 256 + (rem * 256) / mass;
          peaks[cnt] = (c > 65535) ? fdet_pkg::CENT_MAX : 16'(c);
          cnt++;
        end
      end
    end
    r = '0;
    r.peak_count = 5'(cnt);
    if (cnt >= 1) begin
      mult = 1;
      r.encoding = fdet_pkg::ENC_UNKNOWN;
      if (cnt >= 2) begin
        if (4 * longint'(peaks[1]) < 7 * longint'(peaks[0])) begin
          r.encoding = fdet_pkg::ENC_MFM;
          mult = 2;
        end else begin
          r.encoding = fdet_pkg::ENC_FM;
        end
      end
      if (peaks[0] == 16'd0) begin
        r.rate_hz = fdet_pkg::RATE_MAX;
      end else begin
        num = longint'(clk_hz_q) * 256 * mult;
        q   = (num + peaks[0] / 2) / peaks[0];
        r.rate_hz = (q > fdet_pkg::RATE_MAX) ? fdet_pkg::RATE_MAX : 30'(q);
      end
      r.first_peak = peaks[0];
    end
    for (i = 0; i < NBINS; i++) hist_q[i] = '0;
    marks_q = '0;
    return r;
  endfunction

  // Present one item after a random gap (none when no_gaps is set) and hold it until the transfer
  task automatic send_item(input logic kind, input logic [31:0] len, input logic mark);
    int unsigned gap;
    bit          taken;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= '{kind: kind, pulse_len: len, index_mark: mark};
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end while (!taken);
    items_sent++;
    if (kind) report_q.push_back(analyze_track());
    else model_pulse(len, mark);
  endtask

  // Drop start, wait for every report and let the block settle
  task automatic quiesce();
    start_i <= 1'b0;
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(input fdet_pkg::cfg_idx_e idx,
                           input logic [fdet_pkg::CFG_W-1:0] val);
    quiesce();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      fdet_pkg::CFG_REVOLUTION:    rev_q    = val[7:0];
      fdet_pkg::CFG_SAMPLE_CLOCK:  clk_hz_q = val[26:0];
      fdet_pkg::CFG_BIN_THRESHOLD: thr_q    = val[15:0];
      default:                     cmin_q   = val[15:0];
    endcase
  endtask

  task automatic set_all(input logic [7:0] rev, input logic [26:0] hz,
                         input logic [15:0] thr, input logic [15:0] cmin);
    cfg_write(fdet_pkg::CFG_REVOLUTION, fdet_pkg::CFG_W'(rev));
    cfg_write(fdet_pkg::CFG_SAMPLE_CLOCK, fdet_pkg::CFG_W'(hz));
    cfg_write(fdet_pkg::CFG_BIN_THRESHOLD, fdet_pkg::CFG_W'(thr));
    cfg_write(fdet_pkg::CFG_CLUSTER_MIN, fdet_pkg::CFG_W'(cmin));
  endtask

  // One track: marks up to about the chosen revolution, clustered pulses, optional tail, end
  task automatic run_track(input int unsigned npulse);
    int unsigned nmarks, ncl, k;
    int          base [3];
    int          len, jit;
    nmarks = (rev_q == 8'd0) ? 1 : rev_q;
    case ($urandom_range(0, 9))
      0: nmarks = nmarks + 1;
      1: nmarks = (nmarks > 0) ? nmarks - 1 : 0;
      default: ;
    endcase
    ncl = $urandom_range(1, 3);
    base[0] = $urandom_range(6, 70);
    base[1] = base[0] * ($urandom_range(0, 1) ? 3 : 4) / 2;
    base[2] = base[0] * 2;
    for (k = 0; k < nmarks; k++) begin
      if ($urandom_range(0, 1)) send_item(1'b0, 32'd0, 1'($urandom_range(0, 1)));
      else send_item(1'b0, $urandom, 1'b1);
    end
    for (k = 0; k < npulse; k++) begin
      jit = $urandom_range(0, 4) - 2;
      len = base[$urandom_range(0, ncl - 1)] + jit;
      if ($urandom_range(0, 15) == 0) len = $urandom_range(1, 300);
      send_item(1'b0, 32'(len), 1'b0);
    end
    if ($urandom_range(0, 1)) begin
      send_item(1'b0, 32'd0, 1'b0);
      repeat ($urandom_range(0, 3)) send_item(1'b0, $urandom_range(1, 255), 1'b0);
    end
    send_item(1'b1, $urandom, 1'($urandom_range(0, 1)));
  endtask

  // Compare each report strobe against the oldest prediction
  always @(negedge clk_i) begin
    fdet_pkg::result_t want;
    if (rst_ni && done_o) begin
      reports_seen++;
      if (report_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report %p", res_o);
      end else begin
        want = report_q.pop_front();
        if (want.encoding < 3) enc_seen[want.encoding]++;
        if (res_o.encoding !== want.encoding || res_o.rate_hz !== want.rate_hz ||
            res_o.peak_count !== want.peak_count ||
            res_o.first_peak !== want.first_peak) begin
          mismatches++;
          if (mismatches <= 10)
            $display("report mismatch: expected %p, got %p", want, res_o);
        end
      end
    end
  end

  task automatic test_directed();
    int unsigned k;
    send_item(1'b1, 32'hffff_ffff, 1'b1);
    send_item(1'b0, 32'd0, 1'b0);
    send_item(1'b0, 32'hffff_ffff, 1'b0);
    send_item(1'b0, 32'd255, 1'b0);
    send_item(1'b0, 32'd256, 1'b0);
    send_item(1'b0, 32'd1, 1'b0);
    send_item(1'b0, 32'd100, 1'b1);
    send_item(1'b1, 32'd0, 1'b0);
    // Four pulses each of lengths 40 and 60, in MFM ratio
    no_gaps = 1'b1;
    send_item(1'b0, 32'd0, 1'b1);
    for (k = 0; k < 8; k++) send_item(1'b0, (k < 4) ? 32'd40 : 32'd60, 1'b0);
    send_item(1'b1, 32'd0, 1'b0);
    no_gaps = 1'b0;
  endtask

  task automatic test_mark_saturation();
    int unsigned k;
    no_gaps = 1'b1;
    for (k = 0; k < 515; k++) send_item(1'b0, 32'd0, k[0]);
    send_item(1'b0, 32'd50, 1'b0);
    send_item(1'b1, 32'd0, 1'b0);
    no_gaps = 1'b0;
  endtask

  task automatic test_register_extremes();
    set_all(8'd0, 27'd1, 16'd0, 16'd0);
    run_track(6);
    set_all(8'd255, 27'd100000000, 16'd65535, 16'd65535);
    run_track(4);
    set_all(8'd2, 27'd100000000, 16'd1, 16'd2);
    run_track(10);
    run_track(10);
    set_all(8'd1, 27'd24000000, 16'd16, 16'd64);
    run_track(180);
  endtask

  task automatic test_random_tracks();
    int unsigned t;
    set_all(8'd1, 27'd48000000, 16'd2, 16'd4);
    for (t = 0; t < 25; t++) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      run_track($urandom_range(8, 30));
      if (t % 10 == 9)
        set_all(8'($urandom_range(0, 3)), 27'($urandom_range(1, 100000000)),
                16'($urandom_range(0, 4)), 16'($urandom_range(0, 8)));
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_noise();
    int unsigned k;
    for (k = 0; k < 60; k++) begin
      if ($urandom_range(0, 29) == 0) send_item(1'b1, $urandom, 1'($urandom_range(0, 1)));
      else send_item(1'b0, $urandom, 1'($urandom_range(0, 1)));
    end
    send_item(1'b1, 32'd0, 1'b0);
  endtask

  initial begin
    for (int i = 0; i < NBINS; i++) hist_q[i] = '0;
    marks_q  = '0;
    rev_q    = fdet_pkg::REV_RST;
    clk_hz_q = fdet_pkg::CLK_RST;
    thr_q    = fdet_pkg::THR_RST;
    cmin_q   = fdet_pkg::CMIN_RST;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Hold off while the clearing pass runs
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    test_directed();
    test_mark_saturation();
    test_register_extremes();
    test_random_tracks();
    test_noise();
    quiesce();
    $display("Sent %0d items, checked %0d reports (unknown %0d, FM %0d, MFM %0d).",
             items_sent, reports_seen, enc_seen[0], enc_seen[1], enc_seen[2]);
    if (mismatches == 0) begin
      $display("tb_flux_encoding_detector_top OK");
    end else begin
      $display("Mismatches: %0d", mismatches);
      $display("tb_flux_encoding_detector_top NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d reports outstanding", report_q.size());
    $display("tb_flux_encoding_detector_top NOT OK");
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/fdet_pkg.sv
sv/fdet_peak.sv
sv/fdet_div.sv
sv/flux_encoding_detector_top.sv
sv/fdet_checker.sv
test/tb_flux_encoding_detector_top.sv
